/* rtl/core/icrt_pkg.sv */
// Shared types and constants for the in-core inode reference-count table.
// Used by icrt_cfg_regs and inode_cache_refcount_table_unit; no dependencies.
package icrt_pkg;

    localparam int TABLE_ENTRIES    = 64;
    localparam int IDX_W            = $clog2(TABLE_ENTRIES);
    localparam int INODES_PER_BLOCK = 8;
    localparam int OFF_W            = $clog2(INODES_PER_BLOCK);

    localparam int DEV_W    = 4;
    localparam int INO_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int RC_W     = 16;
    localparam int BLK_W    = 32;
    localparam int START_W  = 24;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_INODE_START = 1'b0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    localparam logic [RC_W-1:0] RC_MAX = {RC_W{1'b1}};

    typedef struct packed {
        logic              op;
        logic [DEV_W-1:0]  device;
        logic [INO_W-1:0]  inode_number;
        logic [SLOT_W-1:0] slot_index;
        logic              modified;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                load_needed;
        logic                writeback_needed;
        logic [BLK_W-1:0]    block_number;
        logic [OFF_W-1:0]    inode_offset;
        logic [RC_W-1:0]     ref_count;
    } out_item_t;

    typedef struct packed {
        logic [DEV_W-1:0] device;
        logic [INO_W-1:0] inode;
        logic [RC_W-1:0]  refcount;
        logic             dirty;
    } entry_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCAN    = 6'b000010,
        ST_PUT_RD  = 6'b000100,
        ST_PUT_UPD = 6'b001000,
        ST_PUT_LOC = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

endpackage

/* rtl/core/icrt_cfg_regs.sv */
// APB-style configuration register block: holds the inode table start block.
// Depends on icrt_pkg.
module icrt_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [icrt_pkg::PADDR_W-1:0]  paddr,
    input  logic [icrt_pkg::PDATA_W-1:0]  pwdata,
    output logic [icrt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [icrt_pkg::START_W-1:0]  inode_start_block
);
    import icrt_pkg::*;

    logic [START_W-1:0] start_reg;
    logic [START_W-1:0] start_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        start_next = start_reg;
        if (wr_en && paddr[2] == REG_INODE_START)
        begin
            start_next = pwdata[START_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_INODE_START)
        begin
            prdata = PDATA_W'(start_reg);
        end
    end

    assign inode_start_block = start_reg;

endmodule

/* rtl/core/inode_cache_refcount_table_unit.sv */
// In-core inode table with reference counts (get / put), top level.
// Depends on icrt_pkg and icrt_cfg_regs.
//
// One transaction at a time. A get walks the table through a single read port
// and one device/inode comparator, one entry per cycle, and stops at the first
// hit; a miss (claim or table full) walks every entry. A put reads its slot,
// updates it and, when it reports a write-back, forms the block address in a
// further state. The block address is formed by one shared adder. Valid bits
// clear at reset, so no clearing pass is needed. A result waits in the output
// register while the next request is taken.
module inode_cache_refcount_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  icrt_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output icrt_pkg::out_item_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [icrt_pkg::PADDR_W-1:0]  paddr,
    input  logic [icrt_pkg::PDATA_W-1:0]  pwdata,
    output logic [icrt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import icrt_pkg::*;

    logic [START_W-1:0] start_block;

    icrt_cfg_regs u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .inode_start_block (start_block)
    );

    // control state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    in_item_t             req_reg, req_next;
    logic [INO_W-1:0]     k_reg, k_next;
    out_item_t            res_reg, res_next;
    out_item_t            out_reg, out_next;

    // entry memory
    entry_t               mem [TABLE_ENTRIES];
    entry_t               rd_data_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;

    logic                 in_acc;
    logic                 out_free;
    logic [RC_W-1:0]      eff_rc;
    logic                 eff_dirty;
    logic                 match;
    logic                 free_here;
    logic [IDX_W-1:0]     put_idx;
    logic                 put_in_range;
    logic [RC_W-1:0]      put_rc;
    logic                 put_dirty;
    logic [BLK_W-1:0]     loc_block;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // entries never written read as count zero, clean
    assign eff_rc    = rd_valid_reg ? rd_data_reg.refcount : '0;
    assign eff_dirty = rd_valid_reg && rd_data_reg.dirty;
    assign match     = rd_valid_reg && rd_data_reg.device == req_reg.device
                       && rd_data_reg.inode == req_reg.inode_number;
    assign free_here = free_found_reg || eff_rc == '0;

    assign put_idx      = IDX_W'(req_reg.slot_index);
    assign put_in_range = 32'(req_reg.slot_index) < 32'(TABLE_ENTRIES);
    assign put_rc       = eff_rc - RC_W'(1);
    assign put_dirty    = eff_dirty || req_reg.modified;

    // shared locate unit: block = (ino-1)/8 + start, offset = (ino-1)%8
    assign loc_block = BLK_W'(k_reg[INO_W-1:OFF_W]) + BLK_W'(start_block);

    assign rd_addr = (state_reg == ST_PUT_RD) ? put_idx : scan_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        req_next        = req_reg;
        k_next          = k_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = cmp_idx_reg;
        mem_wdata       = rd_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    req_next        = in_data;
                    k_next          = in_data.inode_number - INO_W'(1);
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = (in_data.op == OP_GET) ? ST_SCAN : ST_PUT_RD;
                end
            end

            ST_SCAN:
            begin
                // issue the next read while comparing the previous entry
                if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                if (cmp_vld_reg)
                begin
                    res_next = '0;
                    if (match)
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = cmp_idx_reg;
                        mem_wdata          = rd_data_reg;
                        mem_wdata.refcount = (rd_data_reg.refcount == RC_MAX)
                                             ? RC_MAX
                                             : rd_data_reg.refcount + RC_W'(1);
                        res_next.status    = STATUS_OK;
                        res_next.slot      = SLOT_W'(cmp_idx_reg);
                        res_next.hit       = 1'b1;
                        res_next.ref_count = mem_wdata.refcount;
                        cmp_vld_next       = 1'b0;
                        state_next         = ST_DONE;
                    end
                    else
                    begin
                        if (!free_found_reg && eff_rc == '0)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                        begin
                            cmp_vld_next = 1'b0;
                            state_next   = ST_DONE;
                            if (free_here)
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = free_found_reg ? free_idx_reg
                                                                    : cmp_idx_reg;
                                mem_wdata.device   = req_reg.device;
                                mem_wdata.inode    = req_reg.inode_number;
                                mem_wdata.refcount = RC_W'(1);
                                mem_wdata.dirty    = 1'b0;
                                valid_next[mem_waddr] = 1'b1;
                                res_next.status       = STATUS_OK;
                                res_next.slot         = SLOT_W'(mem_waddr);
                                res_next.load_needed  = 1'b1;
                                res_next.block_number = loc_block;
                                res_next.inode_offset = k_reg[OFF_W-1:0];
                                res_next.ref_count    = RC_W'(1);
                            end
                            else
                            begin
                                res_next.status = STATUS_NO_FREE;
                            end
                        end
                    end
                end
            end

            ST_PUT_RD:
            begin
                state_next = ST_PUT_UPD;
            end

            ST_PUT_UPD:
            begin
                res_next      = '0;
                res_next.slot = req_reg.slot_index;
                state_next    = ST_DONE;
                if (!put_in_range || eff_rc == '0)
                begin
                    res_next.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = put_idx;
                    mem_wdata          = rd_data_reg;
                    mem_wdata.refcount = put_rc;
                    mem_wdata.dirty    = put_dirty;
                    res_next.status    = STATUS_OK;
                    res_next.ref_count = put_rc;
                    if (put_rc == '0 && put_dirty)
                    begin
                        res_next.writeback_needed = 1'b1;
                        k_next     = rd_data_reg.inode - INO_W'(1);
                        state_next = ST_PUT_LOC;
                    end
                end
            end

            ST_PUT_LOC:
            begin
                res_next.block_number = loc_block;
                res_next.inode_offset = k_reg[OFF_W-1:0];
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        k_reg   <= k_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // a table write during the scan only follows a compared entry
    a_scan_write_has_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_SCAN) |-> cmp_vld_reg)
        else $error("table written during scan without a compared entry");

    a_full_has_no_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == STATUS_NO_FREE) |->
        (out_data.ref_count == '0 && !out_data.hit && !out_data.load_needed))
        else $error("table-full result carries entry fields");

    a_hit_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> (out_data.ref_count != '0))
        else $error("hit reported with zero reference count");

    a_load_is_fresh_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.load_needed) |->
        (out_data.ref_count == RC_W'(1) && !out_data.hit))
        else $error("load reported on a non-fresh entry");

    a_writeback_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.writeback_needed) |-> (out_data.ref_count == '0))
        else $error("write-back reported on a referenced entry");

endmodule

/* test/tb.sv */
// Testbench for the in-core inode reference-count table (get / put with load and write-back).
// Depends on icrt_pkg and the inode_cache_refcount_table_unit RTL.
// A tracker class predicts each response and checks it. Plain tasks drive requests and APB writes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_ITEMS    = 267;

    class inode_table_tracker;
        logic [START_W-1:0] start_block;
        logic               valid    [TABLE_ENTRIES];
        logic [DEV_W-1:0]   dev      [TABLE_ENTRIES];
        logic [INO_W-1:0]   ino      [TABLE_ENTRIES];
        logic [RC_W-1:0]    rc       [TABLE_ENTRIES];
        logic               dirty    [TABLE_ENTRIES];
        out_item_t          expected_responses[$];
        int                 errors;

        function new();
            int i;
            start_block = '0;
            errors = 0;
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid[i] = 1'b0;
                dev[i]   = '0;
                ino[i]   = '0;
                rc[i]    = '0;
                dirty[i] = 1'b0;
            end
        endfunction

        function void locate(input logic [INO_W-1:0] inode, output logic [BLK_W-1:0] blk,
                             output logic [OFF_W-1:0] off);
            logic [INO_W-1:0] k;
            k = inode - 1'b1;
            blk = BLK_W'(k / INODES_PER_BLOCK) + BLK_W'(start_block);
            off = OFF_W'(k % INODES_PER_BLOCK);
        endfunction

        // Predict the response of one accepted request and update the table copy.
        function void note_request(in_item_t req);
            out_item_t rsp;
            int        i;
            bit        found;
            rsp = '0;
            found = 1'b0;
            if (req.op == OP_GET)
            begin
                for (i = 0; i < TABLE_ENTRIES && !found; i++)
                begin
                    if (valid[i] && dev[i] == req.device && ino[i] == req.inode_number)
                    begin
                        found = 1'b1;
                        if (rc[i] != RC_MAX)
                            rc[i] = rc[i] + 1'b1;
                        rsp.slot      = SLOT_W'(i);
                        rsp.hit       = 1'b1;
                        rsp.ref_count = rc[i];
                    end
                end
                for (i = 0; i < TABLE_ENTRIES && !found; i++)
                begin
                    if (rc[i] == 0)
                    begin
                        found    = 1'b1;
                        valid[i] = 1'b1;
                        dev[i]   = req.device;
                        ino[i]   = req.inode_number;
                        rc[i]    = RC_W'(1);
                        dirty[i] = 1'b0;
                        rsp.slot        = SLOT_W'(i);
                        rsp.load_needed = 1'b1;
                        locate(req.inode_number, rsp.block_number, rsp.inode_offset);
                        rsp.ref_count   = RC_W'(1);
                    end
                end
                if (!found)
                    rsp.status = STATUS_NO_FREE;
            end
            else
            begin
                rsp.slot = req.slot_index;
                if (int'(req.slot_index) >= TABLE_ENTRIES || rc[req.slot_index] == 0)
                    rsp.status = STATUS_UNDERFLOW;
                else
                begin
                    if (req.modified)
                        dirty[req.slot_index] = 1'b1;
                    rc[req.slot_index] = rc[req.slot_index] - 1'b1;
                    rsp.ref_count = rc[req.slot_index];
                    if (rc[req.slot_index] == 0 && dirty[req.slot_index])
                    begin
                        rsp.writeback_needed = 1'b1;
                        locate(ino[req.slot_index], rsp.block_number, rsp.inode_offset);
                    end
                end
            end
            expected_responses.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [BLK_W-1:0] want, logic [BLK_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(out_item_t got);
            out_item_t want;
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response with none outstanding, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            compare_field("status", BLK_W'(want.status), BLK_W'(got.status));
            compare_field("slot", BLK_W'(want.slot), BLK_W'(got.slot));
            compare_field("hit", BLK_W'(want.hit), BLK_W'(got.hit));
            compare_field("load_needed", BLK_W'(want.load_needed), BLK_W'(got.load_needed));
            compare_field("writeback_needed", BLK_W'(want.writeback_needed),
                          BLK_W'(got.writeback_needed));
            compare_field("block_number", want.block_number, got.block_number);
            compare_field("inode_offset", BLK_W'(want.inode_offset), BLK_W'(got.inode_offset));
            compare_field("ref_count", BLK_W'(want.ref_count), BLK_W'(got.ref_count));
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    in_item_t            in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    inode_table_tracker table_model = new();

    inode_cache_refcount_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side: check accepted transactions, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_model.check_response(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("inode_cache_refcount_table_unit verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        table_model.note_request(req);
    endtask

    function automatic in_item_t random_fields();
        in_item_t req;
        req.op           = 1'($urandom_range(1));
        req.device       = DEV_W'($urandom_range(15));
        req.inode_number = INO_W'($urandom);
        req.slot_index   = SLOT_W'($urandom_range(63));
        req.modified     = 1'($urandom_range(1));
        return req;
    endfunction

    task automatic send_get(logic [DEV_W-1:0] device, logic [INO_W-1:0] inode);
        in_item_t req;
        req = random_fields();
        req.op           = OP_GET;
        req.device       = device;
        req.inode_number = inode;
        send_item(req);
    endtask

    task automatic send_put(logic [SLOT_W-1:0] slot, logic modified);
        in_item_t req;
        req = random_fields();
        req.op         = OP_PUT;
        req.slot_index = slot;
        req.modified   = modified;
        send_item(req);
    endtask

    // Drop valid and hold until every predicted response has been checked.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (table_model.expected_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_start_block(logic [START_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_INODE_START));
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        table_model.start_block = value;
    endtask

    // Mostly gets from a small device/inode pool so hits, claims and a full table occur;
    // puts mostly land on held slots.
    function automatic in_item_t make_request(int get_pct);
        in_item_t req;
        int       held[$];
        int       i;
        req = random_fields();
        if ($urandom_range(99) < get_pct)
        begin
            req.op = OP_GET;
            case ($urandom_range(19))
                0:       req.inode_number = '0;
                1, 2:    ;
                default:
                begin
                    req.device       = DEV_W'($urandom_range(3));
                    req.inode_number = INO_W'($urandom_range(24, 1));
                end
            endcase
        end
        else
        begin
            req.op = OP_PUT;
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (table_model.rc[i] != 0)
                    held.push_back(i);
            if (held.size() != 0 && $urandom_range(9) < 8)
                req.slot_index = SLOT_W'(held[$urandom_range(held.size() - 1)]);
        end
        return req;
    endfunction

    task automatic run_random(int count);
        int i;
        int get_pct;
        get_pct = 50;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       get_pct = 25;
                    1:       get_pct = 50;
                    default: get_pct = 85;
                endcase
            end
            if ($urandom_range(99) == 0)
                drain();
            send_item(make_request(get_pct));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct  = 7;
        recv_stall_pct = 72;
        write_start_block(24'hFFFFFF);

        send_get(4'd0, 32'd1);             // claim slot 0
        send_get(4'd0, 32'd1);             // hit, count 2
        send_get(4'hF, 32'hFFFFFFFF);      // claim slot 1, largest inode
        send_get(4'd0, 32'd0);             // inode zero wraps to offset 7
        send_get(4'd1, 32'd1);             // same inode, other device
        send_get(4'd0, 32'd9);
        send_put(6'd0, 1'b0);
        send_put(6'd0, 1'b1);              // count zero on dirty entry
        send_put(6'd0, 1'b1);              // underflow
        send_get(4'd0, 32'd1);             // valid entry at count zero still hits
        send_put(6'd0, 1'b0);              // dirty mark survives the write-back
        send_get(4'd2, 32'd100);           // reclaim slot 0, dirty cleared
        send_put(6'd0, 1'b0);
        send_put(6'd63, 1'b1);             // never used slot
        send_put(6'd1, 1'b1);
        send_put(6'd2, 1'b0);
        send_put(6'd3, 1'b1);
        send_put(6'd4, 1'b0);

        write_start_block(START_W'($urandom));
        run_random(PHASE_ITEMS);

        send_idle_pct  = 72;
        recv_stall_pct = 7;
        write_start_block('0);
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_start_block(START_W'($urandom));
        run_random(PHASE_ITEMS - 1);

        // Touch the slot 0 entry again under a new start block.
        write_start_block(24'd1);
        send_get(table_model.dev[0], table_model.ino[0]);
        send_put(6'd0, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (table_model.errors == 0 && table_model.expected_responses.size() == 0)
            $display("inode_cache_refcount_table_unit verification clean");
        else
            $display("inode_cache_refcount_table_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/icrt_pkg.sv
rtl/core/icrt_cfg_regs.sv
rtl/core/inode_cache_refcount_table_unit.sv
test/tb.sv
